[design/epr_pkg.sv]
// ----------------------------------------------------------------------------
// epr_pkg: shared constants for the Euler point rotation block
// Register indexes, sine polynomial coefficients and the microprogram that
// builds the rotation matrix from the six sines and cosines.
// ----------------------------------------------------------------------------
package epr_pkg;

	localparam logic [2:0] REG_ALPHA   = 3'd0;
	localparam logic [2:0] REG_BETA    = 3'd1;
	localparam logic [2:0] REG_GAMMA   = 3'd2;
	localparam logic [2:0] REG_REVERSE = 3'd3;
	localparam logic [2:0] REG_CX      = 3'd4;
	localparam logic [2:0] REG_CY      = 3'd5;
	localparam logic [2:0] REG_CZ      = 3'd6;

	// operand codes of the matrix microprogram
	localparam logic [3:0] OP_SA  = 4'd0;
	localparam logic [3:0] OP_CA  = 4'd1;
	localparam logic [3:0] OP_SB  = 4'd2;
	localparam logic [3:0] OP_CB  = 4'd3;
	localparam logic [3:0] OP_SG  = 4'd4;
	localparam logic [3:0] OP_CG  = 4'd5;
	localparam logic [3:0] OP_T0  = 4'd6;
	localparam logic [3:0] OP_T1  = 4'd7;
	localparam logic [3:0] OP_ONE = 4'd8;

	// destinations: 0..8 are matrix entries, then the two temporaries
	localparam logic [3:0] DST_T0 = 4'd9;
	localparam logic [3:0] DST_T1 = 4'd10;

	localparam logic [3:0] MAT_LAST_STEP = 4'd14;
	localparam logic [2:0] SINE_LAST_MUL = 3'd6;
	localparam logic [2:0] SINE_LAST_IDX = 3'd5;

	typedef struct packed {
		logic [3:0] opa;
		logic [3:0] opb;
		logic       neg;
		logic       first;
		logic       last;
		logic [3:0] dest;
	} mstep_t;

	function automatic logic [31:0] sine_coef(input logic [2:0] i);
		logic [31:0] c;
		case (i)
			3'd0:    c = 32'd1686629713;
			3'd1:    c = 32'd693598669;
			3'd2:    c = 32'd85569306;
			3'd3:    c = 32'd5026995;
			3'd4:    c = 32'd172272;
			3'd5:    c = 32'd3864;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

	function automatic mstep_t mat_step(input logic [3:0] i);
		mstep_t s;
		case (i)
			4'd0:    s = '{OP_CG, OP_CB,  1'b0, 1'b1, 1'b1, DST_T0};
			4'd1:    s = '{OP_SG, OP_CB,  1'b0, 1'b1, 1'b1, DST_T1};
			4'd2:    s = '{OP_T0, OP_CA,  1'b0, 1'b1, 1'b0, 4'd0};
			4'd3:    s = '{OP_SG, OP_SA,  1'b1, 1'b0, 1'b1, 4'd0};
			4'd4:    s = '{OP_T1, OP_CA,  1'b0, 1'b1, 1'b0, 4'd1};
			4'd5:    s = '{OP_CG, OP_SA,  1'b0, 1'b0, 1'b1, 4'd1};
			4'd6:    s = '{OP_SB, OP_CA,  1'b1, 1'b1, 1'b1, 4'd2};
			4'd7:    s = '{OP_T0, OP_SA,  1'b1, 1'b1, 1'b0, 4'd3};
			4'd8:    s = '{OP_SG, OP_CA,  1'b1, 1'b0, 1'b1, 4'd3};
			4'd9:    s = '{OP_T1, OP_SA,  1'b1, 1'b1, 1'b0, 4'd4};
			4'd10:   s = '{OP_CG, OP_CA,  1'b0, 1'b0, 1'b1, 4'd4};
			4'd11:   s = '{OP_SB, OP_SA,  1'b0, 1'b1, 1'b1, 4'd5};
			4'd12:   s = '{OP_CG, OP_SB,  1'b0, 1'b1, 1'b1, 4'd6};
			4'd13:   s = '{OP_SG, OP_SB,  1'b0, 1'b1, 1'b1, 4'd7};
			4'd14:   s = '{OP_CB, OP_ONE, 1'b0, 1'b1, 1'b1, 4'd8};
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

[design/epr_coef_gen.sv]
// ----------------------------------------------------------------------------
// epr_coef_gen: rotation matrix builder
// Evaluates six sines/cosines with a shared Q30 multiplier, then runs a short
// multiply-accumulate microprogram to form the nine Q1.F coefficients.
// ----------------------------------------------------------------------------
module epr_coef_gen
	import epr_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int COEF_BITS  = 18
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ANGLE_BITS-1:0]       alpha,
	input  logic [ANGLE_BITS-1:0]       beta,
	input  logic [ANGLE_BITS-1:0]       gamma,
	output logic                        busy,
	output logic signed [COEF_BITS-1:0] coef [9]
);

	localparam int F  = COEF_BITS - 2;
	localparam int AW = 2 * COEF_BITS + 2;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [30:0] X_ONE = 31'h4000_0000;
	localparam logic signed [COEF_BITS-1:0] C_ONE = COEF_BITS'(1) << F;
	localparam logic signed [AW-1:0] RND = AW'(1) << (F - 1);
	localparam logic signed [AW-1:0] CMAX =
		signed'({{(AW-COEF_BITS+1){1'b0}}, {(COEF_BITS-1){1'b1}}});
	localparam logic signed [AW-1:0] CMIN =
		signed'({{(AW-COEF_BITS+1){1'b1}}, {(COEF_BITS-1){1'b0}}});

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SINE  = 2'd1;
	localparam logic [1:0] ST_MAT   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0] state_q;
	logic [2:0] sidx_q;
	logic [2:0] kstep_q;
	logic       ph_q;
	logic [3:0] mstep_q;

	logic [30:0] x2_q;
	logic [31:0] p_q;
	logic [62:0] sprod_q;

	logic signed [COEF_BITS-1:0] sa_q, ca_q, sb_q, cb_q, sg_q, cg_q, t0_q, t1_q;
	logic signed [COEF_BITS-1:0] coef_q [9];

	logic signed [2*COEF_BITS-1:0] mprod_q;
	mstep_t                        mctl_q;
	logic                          mvld_q;
	logic signed [AW-1:0]          acc_q;

	// sine argument
	logic [ANGLE_BITS-1:0] ang_base, ang;
	logic [31:0]           u;
	logic [30:0]           x;
	logic [30:0]           mul_a;
	logic [31:0]           mul_b;
	logic [31:0]           s_val;
	logic [32:0]           vr;
	logic [32:0]           vcap;
	logic signed [COEF_BITS-1:0] tv;

	always_comb begin
		unique case (sidx_q[2:1])
			2'd0:    ang_base = alpha;
			2'd1:    ang_base = beta;
			default: ang_base = gamma;
		endcase
		ang = ang_base + (sidx_q[0] ? QUARTER : '0);
		u   = {ang, {(32-ANGLE_BITS){1'b0}}};
		x   = u[30] ? (X_ONE - {1'b0, u[29:0]}) : {1'b0, u[29:0]};
		mul_a = (kstep_q == 3'd0 || kstep_q == SINE_LAST_MUL) ? x : x2_q;
		if (kstep_q == 3'd0) begin
			mul_b = {1'b0, x};
		end else if (kstep_q == 3'd1) begin
			mul_b = sine_coef(3'd5);
		end else begin
			mul_b = p_q;
		end
		s_val = sprod_q[61:30];
		vr    = ({1'b0, s_val} + (33'd1 << (29 - F))) >> (30 - F);
		vcap  = (vr > (33'd1 << F)) ? (33'd1 << F) : vr;
		tv    = u[31] ? -COEF_BITS'(vcap) : COEF_BITS'(vcap);
	end

	function automatic logic signed [COEF_BITS-1:0] op_sel(
		input logic [3:0] code,
		input logic signed [COEF_BITS-1:0] sa, ca, sb, cb, sg, cg, t0, t1
	);
		logic signed [COEF_BITS-1:0] r;
		case (code)
			OP_SA:   r = sa;
			OP_CA:   r = ca;
			OP_SB:   r = sb;
			OP_CB:   r = cb;
			OP_SG:   r = sg;
			OP_CG:   r = cg;
			OP_T0:   r = t0;
			OP_T1:   r = t1;
			OP_ONE:  r = C_ONE;
			default: r = '0;
		endcase
		return r;
	endfunction

	mstep_t ms;
	logic signed [COEF_BITS-1:0] opa, opb;
	logic signed [AW-1:0] term, sum, rr, cl;

	always_comb begin
		ms   = mat_step(mstep_q);
		opa  = op_sel(ms.opa, sa_q, ca_q, sb_q, cb_q, sg_q, cg_q, t0_q, t1_q);
		opb  = op_sel(ms.opb, sa_q, ca_q, sb_q, cb_q, sg_q, cg_q, t0_q, t1_q);
		term = mctl_q.neg ? -AW'(mprod_q) : AW'(mprod_q);
		sum  = mctl_q.first ? term : acc_q + term;
		rr   = (sum + RND) >>> F;
		if (rr > CMAX) begin
			cl = CMAX;
		end else if (rr < CMIN) begin
			cl = CMIN;
		end else begin
			cl = rr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sidx_q  <= '0;
			kstep_q <= '0;
			ph_q    <= 1'b0;
			mstep_q <= '0;
			mvld_q  <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				coef_q[i] <= (i % 4 == 0) ? C_ONE : '0;
			end
		end else begin
			mvld_q <= (state_q == ST_MAT);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SINE;
						sidx_q  <= '0;
						kstep_q <= '0;
						ph_q    <= 1'b0;
					end
				end
				ST_SINE: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (kstep_q == SINE_LAST_MUL) begin
							kstep_q <= '0;
							if (sidx_q == SINE_LAST_IDX) begin
								state_q <= ST_MAT;
								mstep_q <= '0;
							end else begin
								sidx_q <= sidx_q + 3'd1;
							end
						end else begin
							kstep_q <= kstep_q + 3'd1;
						end
					end
				end
				ST_MAT: begin
					if (mstep_q == MAT_LAST_STEP) begin
						state_q <= ST_DRAIN;
					end else begin
						mstep_q <= mstep_q + 4'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (mvld_q && mctl_q.last && mctl_q.dest < 4'd9) begin
				coef_q[mctl_q.dest] <= COEF_BITS'(cl);
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_SINE) begin
			if (!ph_q) begin
				sprod_q <= {32'd0, mul_a} * {31'd0, mul_b};
			end else begin
				if (kstep_q == 3'd0) begin
					x2_q <= sprod_q[60:30];
				end else if (kstep_q == SINE_LAST_MUL) begin
					unique case (sidx_q)
						3'd0:    sa_q <= tv;
						3'd1:    ca_q <= tv;
						3'd2:    sb_q <= tv;
						3'd3:    cb_q <= tv;
						3'd4:    sg_q <= tv;
						default: cg_q <= tv;
					endcase
				end else begin
					p_q <= sine_coef(3'd5 - kstep_q) - sprod_q[61:30];
				end
			end
		end
		if (state_q == ST_MAT) begin
			mprod_q <= opa * opb;
			mctl_q  <= ms;
		end
		if (mvld_q) begin
			acc_q <= sum;
			if (mctl_q.last && mctl_q.dest == DST_T0) begin
				t0_q <= COEF_BITS'(cl);
			end
			if (mctl_q.last && mctl_q.dest == DST_T1) begin
				t1_q <= COEF_BITS'(cl);
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign coef = coef_q;

	a_mat_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mvld_q |-> $past(state_q == ST_MAT))
		else $error("matrix step retired without issue");
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == ST_IDLE) |=> state_q == ST_SINE)
		else $error("builder did not start");
	a_sine_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SINE && !ph_q) |=> ph_q)
		else $error("sine writeback phase skipped");

endmodule

[design/euler_point_rotation_unit.sv]
// ----------------------------------------------------------------------------
// euler_point_rotation_unit: rotate 3D points about a center by Euler angles
// Usage: write angles, reverse flag and center on the cfg channel (cfg_index,
// cfg_data, cfg_valid/cfg_ready), then stream points on pos_x/y/z with
// in_last marking the last point of a molecule. Each accepted word gives one
// rotated, saturated word on rot_x/y/z with out_last copied through.
// A write to an angle register or the reverse flag rebuilds the matrix: the
// builder evaluates six sines on one shared Q30 multiplier, then runs a
// 15-step multiply-accumulate. cfg_ready and in_ready stay low meanwhile.
// Point path: four register stages (subtract center, multiply, sum, round,
// add center and saturate), one word per cycle while out_ready is high and
// no rebuild is running. Reset loads the identity matrix and clears the
// config registers and valid flags; the datapath registers have no reset.
// When out_ready is low the stages fill up and hold; in_ready drops once
// they are all full, and no word is lost or repeated.
// ----------------------------------------------------------------------------
module euler_point_rotation_unit
	import epr_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int ANGLE_BITS = 16,
	parameter int COEF_BITS  = 18
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [((COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS)-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic in_last,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [COORD_BITS-1:0] rot_x,
	output logic signed [COORD_BITS-1:0] rot_y,
	output logic signed [COORD_BITS-1:0] rot_z,
	output logic out_last
);

	localparam int F   = COEF_BITS - 2;
	localparam int D   = COORD_BITS + 1;
	localparam int DH  = D - F;
	localparam int PH  = COEF_BITS + DH;
	localparam int PL  = COEF_BITS + F + 1;
	localparam int VW  = ((PH > PL) ? PH : PL) + 4;
	localparam logic signed [PL+1:0] LRND = (PL+2)'(1) << (F - 1);
	localparam logic signed [VW-1:0] SAT_HI =
		signed'({{(VW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
	localparam logic signed [VW-1:0] SAT_LO =
		signed'({{(VW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}});

	logic [ANGLE_BITS-1:0]        alpha_q, beta_q, gamma_q;
	logic                         rev_q;
	logic signed [COORD_BITS-1:0] ctr_q [3];
	logic                         start_q;
	logic                         gen_busy;
	logic                         blocked;
	logic                         cfg_fire;
	logic                         in_fire;

	logic [ANGLE_BITS-1:0] a_eff, b_eff, g_eff;
	logic signed [COEF_BITS-1:0] coef [9];

	assign blocked   = start_q | gen_busy;
	assign cfg_ready = !blocked;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= '0;
			gamma_q <= '0;
			rev_q   <= 1'b0;
			ctr_q[0] <= '0;
			ctr_q[1] <= '0;
			ctr_q[2] <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= cfg_fire && (cfg_index <= REG_REVERSE);
			if (cfg_fire) begin
				case (cfg_index)
					REG_ALPHA:   alpha_q  <= cfg_data[ANGLE_BITS-1:0];
					REG_BETA:    beta_q   <= cfg_data[ANGLE_BITS-1:0];
					REG_GAMMA:   gamma_q  <= cfg_data[ANGLE_BITS-1:0];
					REG_REVERSE: rev_q    <= cfg_data[0];
					REG_CX:      ctr_q[0] <= cfg_data[COORD_BITS-1:0];
					REG_CY:      ctr_q[1] <= cfg_data[COORD_BITS-1:0];
					REG_CZ:      ctr_q[2] <= cfg_data[COORD_BITS-1:0];
					default:     ;
				endcase
			end
		end
	end

	// inverse rotation: swap alpha and gamma, negate all three
	assign a_eff = rev_q ? (ANGLE_BITS'(0) - gamma_q) : alpha_q;
	assign b_eff = rev_q ? (ANGLE_BITS'(0) - beta_q)  : beta_q;
	assign g_eff = rev_q ? (ANGLE_BITS'(0) - alpha_q) : gamma_q;

	epr_coef_gen #(
		.ANGLE_BITS(ANGLE_BITS),
		.COEF_BITS (COEF_BITS)
	) u_coef_gen (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.alpha (a_eff),
		.beta  (b_eff),
		.gamma (g_eff),
		.busy  (gen_busy),
		.coef  (coef)
	);

	// point pipeline
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [COORD_BITS-1:0] pos [3];
	logic signed [D-1:0]          d_s1 [3];
	logic signed [PH-1:0]         phi_s2 [9];
	logic signed [PL-1:0]         plo_s2 [9];
	logic signed [PH+1:0]         hi_s3 [3];
	logic signed [PL+1:0]         lo_s3 [3];
	logic signed [COORD_BITS-1:0] rot_s4 [3];
	logic signed [VW-1:0]         vsum [3];

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1 && !blocked;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			vsum[r] = VW'(hi_s3[r]) + VW'((lo_s3[r] + LRND) >>> F) + VW'(ctr_q[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_fire;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			last_s1 <= in_last;
			for (int c = 0; c < 3; c++) begin
				d_s1[c] <= D'(pos[c]) - D'(ctr_q[c]);
			end
		end
		if (en2) begin
			last_s2 <= last_s1;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					phi_s2[r*3+c] <= PH'(coef[r*3+c]) * PH'(signed'(d_s1[c][D-1:F]));
					plo_s2[r*3+c] <= PL'(coef[r*3+c]) * PL'(signed'({1'b0, d_s1[c][F-1:0]}));
				end
			end
		end
		if (en3) begin
			last_s3 <= last_s2;
			for (int r = 0; r < 3; r++) begin
				hi_s3[r] <= (PH+2)'(phi_s2[r*3]) + (PH+2)'(phi_s2[r*3+1])
					+ (PH+2)'(phi_s2[r*3+2]);
				lo_s3[r] <= (PL+2)'(plo_s2[r*3]) + (PL+2)'(plo_s2[r*3+1])
					+ (PL+2)'(plo_s2[r*3+2]);
			end
		end
		if (en4) begin
			last_s4 <= last_s3;
			for (int r = 0; r < 3; r++) begin
				if (vsum[r] > SAT_HI) begin
					rot_s4[r] <= SAT_HI[COORD_BITS-1:0];
				end else if (vsum[r] < SAT_LO) begin
					rot_s4[r] <= SAT_LO[COORD_BITS-1:0];
				end else begin
					rot_s4[r] <= vsum[r][COORD_BITS-1:0];
				end
			end
		end
	end

	assign out_valid = v_s4;
	assign rot_x     = rot_s4[0];
	assign rot_y     = rot_s4[1];
	assign rot_z     = rot_s4[2];
	assign out_last  = last_s4;

	a_no_point_while_building: assert property (@(posedge clk) disable iff (!arst_n)
		gen_busy |-> !in_fire)
		else $error("word accepted while matrix rebuilds");
	a_start_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> gen_busy)
		else $error("matrix rebuild did not start");
	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !out_ready) |=> (v_s4 && $stable(rot_s4[0]) && $stable(last_s4)))
		else $error("stalled result changed");

endmodule
